// ===== rtl/core/telnet_rf_pkg.sv =====
package telnet_rf_pkg;

	localparam logic [7:0] IAC      = 8'd255;
	localparam logic [7:0] DONT     = 8'd254;
	localparam logic [7:0] DO       = 8'd253;
	localparam logic [7:0] WONT     = 8'd252;
	localparam logic [7:0] WILL     = 8'd251;
	localparam logic [7:0] OPT_ECHO = 8'd1;

	localparam logic KIND_DATA  = 1'b0;
	localparam logic KIND_REPLY = 1'b1;

endpackage

// ===== rtl/core/telnet_option_receive_filter.sv =====
// Telnet receive filter: takes one received byte per request on the rx channel and gives
// at most one result per byte on the res channel, either a data byte for the application
// (out_kind 0) or a negotiation reply for the peer (out_kind 1, reply_cmd/reply_opt).
// IAC IAC gives data 255, IAC with an unknown byte passes that byte as data, and IAC with
// DO/DONT/WILL/WONT takes the next byte as the option; ECHO is negotiated against
// logged_in, other options are refused. A byte can be taken every cycle unless rx_stall is
// up: each byte passes an input register and then a result register before its result is
// offered, and rx_stall rises only while the input register is full and a waiting
// result is held by res_stall. Bytes that give no result are consumed without a res request.
module telnet_option_receive_filter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rx_valid,
	output logic                rx_stall,
	input  logic [7:0]          rx_byte,
	input  logic                logged_in,
	output logic                res_valid,
	input  logic                res_stall,
	output logic                out_kind,
	output logic [7:0]          data_byte,
	output logic [7:0]          reply_cmd,
	output logic [7:0]          reply_opt
);
	import telnet_rf_pkg::*;

	typedef enum logic [1:0] {
		PH_DATA = 2'd0,
		PH_IAC  = 2'd1,
		PH_OPT  = 2'd2
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] cmd_q, cmd_d;
	logic       echo_neg_q, echo_neg_d;
	logic       echo_req_q, echo_req_d;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       login_s1;

	logic       res_valid_q;
	logic       kind_q;
	logic [7:0] data_q, rcmd_q, ropt_q;

	logic       emit;
	logic       kind_d;
	logic [7:0] data_d, rcmd_d, ropt_d;
	logic       out_free;

	assign out_free  = !res_valid_q || !res_stall;
	assign rx_stall  = valid_s1 && !out_free;
	assign res_valid = res_valid_q;
	assign out_kind  = kind_q;
	assign data_byte = data_q;
	assign reply_cmd = rcmd_q;
	assign reply_opt = ropt_q;

	always_comb begin
		phase_d    = PH_DATA;
		cmd_d      = cmd_q;
		echo_neg_d = echo_neg_q;
		echo_req_d = echo_req_q;
		emit       = 1'b0;
		kind_d     = KIND_DATA;
		data_d     = 8'd0;
		rcmd_d     = 8'd0;
		ropt_d     = 8'd0;
		unique case (phase_q)
			PH_IAC: begin
				if (byte_s1 == IAC) begin
					emit   = 1'b1;
					data_d = IAC;
				end else if (byte_s1 inside {DO, DONT, WILL, WONT}) begin
					cmd_d   = byte_s1;
					phase_d = PH_OPT;
				end else begin
					emit   = 1'b1;
					data_d = byte_s1;
				end
			end
			PH_OPT: begin
				ropt_d = byte_s1;
				kind_d = KIND_REPLY;
				if (byte_s1 == OPT_ECHO) begin
					case (cmd_q)
						DO: begin
							if (echo_neg_q != login_s1) begin
								echo_neg_d = login_s1;
								emit       = 1'b1;
								rcmd_d     = login_s1 ? WILL : WONT;
							end
							echo_req_d = 1'b1;
						end
						DONT: begin
							if (echo_neg_q) begin
								echo_neg_d = 1'b0;
								emit       = echo_req_q;
								rcmd_d     = WONT;
							end
							echo_req_d = 1'b0;
						end
						WILL: begin
							emit   = 1'b1;
							rcmd_d = DONT;
						end
						default: ;
					endcase
				end else begin
					case (cmd_q)
						WILL: begin
							emit   = 1'b1;
							rcmd_d = DONT;
						end
						DO: begin
							emit   = 1'b1;
							rcmd_d = WONT;
						end
						default: ;
					endcase
				end
			end
			default: begin
				if (byte_s1 == IAC) begin
					phase_d = PH_IAC;
				end else begin
					emit   = 1'b1;
					data_d = byte_s1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_DATA;
			cmd_q       <= 8'd0;
			echo_neg_q  <= 1'b0;
			echo_req_q  <= 1'b0;
			valid_s1    <= 1'b0;
			byte_s1     <= 8'd0;
			login_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			kind_q      <= KIND_DATA;
			data_q      <= 8'd0;
			rcmd_q      <= 8'd0;
			ropt_q      <= 8'd0;
		end else begin
			if (!rx_stall) begin
				valid_s1 <= rx_valid;
				if (rx_valid) begin
					byte_s1  <= rx_byte;
					login_s1 <= logged_in;
				end
			end
			if (out_free) begin
				res_valid_q <= valid_s1 && emit;
				if (valid_s1) begin
					phase_q    <= phase_d;
					cmd_q      <= cmd_d;
					echo_neg_q <= echo_neg_d;
					echo_req_q <= echo_req_d;
					if (emit) begin
						kind_q <= kind_d;
						data_q <= data_d;
						rcmd_q <= rcmd_d;
						ropt_q <= ropt_d;
					end
				end
			end
		end
	end

endmodule

// ===== rtl/core/telnet_rf_checker.sv =====
module telnet_rf_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       res_valid,
	input  logic       res_stall,
	input  logic       out_kind,
	input  logic [7:0] data_byte,
	input  logic [7:0] reply_cmd,
	input  logic [7:0] reply_opt
);
	import telnet_rf_pkg::*;

	// a stalled result request stays up
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result request dropped while stalled");

	a_reply_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && out_kind == KIND_REPLY |->
			reply_cmd == WILL || reply_cmd == WONT || reply_cmd == DONT)
		else $error("reply carries an invalid command");

	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && out_kind == KIND_DATA |-> reply_cmd == 8'd0 && reply_opt == 8'd0)
		else $error("data result carries reply fields");

	// only ECHO is ever agreed to
	a_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && out_kind == KIND_REPLY && reply_opt != OPT_ECHO |->
			data_byte == 8'd0 && (reply_cmd == DONT || reply_cmd == WONT))
		else $error("non-echo option not refused");

endmodule

bind telnet_option_receive_filter telnet_rf_checker u_telnet_rf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.out_kind  (out_kind),
	.data_byte (data_byte),
	.reply_cmd (reply_cmd),
	.reply_opt (reply_opt)
);

// ===== tb/sv/tb_telnet_option_receive_filter.sv =====
module tb_telnet_option_receive_filter;
	timeunit 1ns;
	timeprecision 1ps;

	import telnet_rf_pkg::*;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic [7:0] cmd;
		logic [7:0] opt;
	} filter_res_t;

	typedef struct packed {
		logic [7:0]  rx;
		logic        li;
		logic        fixed;
		logic        has;
		filter_res_t res;
	} stim_row_t;

	typedef enum logic [1:0] {
		PH_DATA = 2'd0,
		PH_IAC  = 2'd1,
		PH_OPT  = 2'd2
	} parse_phase_t;

	localparam int NUM_RANDOM  = 1525;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_LIMIT = 20000;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       rx_valid  = 1'b0;
	logic       rx_stall;
	logic [7:0] rx_byte   = 8'd0;
	logic       logged_in = 1'b0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic       out_kind;
	logic [7:0] data_byte;
	logic [7:0] reply_cmd;
	logic [7:0] reply_opt;

	// directed-row tags, travel with the payload
	logic        row_fixed = 1'b0;
	logic        row_has   = 1'b0;
	filter_res_t row_res   = '0;

	parse_phase_t phase_q    = PH_DATA;
	logic [7:0]   held_cmd_q = 8'd0;
	logic         echo_on_q  = 1'b0;
	logic         echo_ask_q = 1'b0;

	filter_res_t pending_results[$];
	int          mismatches   = 0;
	int          tx_idle_pct  = 0;
	int          rx_idle_pct  = 0;
	bit          hold_request = 1'b0;
	bit          hold_done    = 1'b0;
	logic        li_state     = 1'b0;

	telnet_option_receive_filter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_stall  (rx_stall),
		.rx_byte   (rx_byte),
		.logged_in (logged_in),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.out_kind  (out_kind),
		.data_byte (data_byte),
		.reply_cmd (reply_cmd),
		.reply_opt (reply_opt)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic filter_res_t data_res(input logic [7:0] b);
		data_res = '{kind: KIND_DATA, data: b, cmd: 8'd0, opt: 8'd0};
	endfunction

	function automatic filter_res_t reply_res(input logic [7:0] c, input logic [7:0] o);
		reply_res = '{kind: KIND_REPLY, data: 8'd0, cmd: c, opt: o};
	endfunction

	// option handling, updates echo state
	function automatic logic negotiate(input logic [7:0] c, input logic [7:0] o,
			input logic li, output filter_res_t r);
		negotiate = 1'b0;
		r = '0;
		if (o == OPT_ECHO) begin
			if (c == DO) begin
				if (echo_on_q != li) begin
					echo_on_q = li;
					r = reply_res(li ? WILL : WONT, OPT_ECHO);
					negotiate = 1'b1;
				end
				echo_ask_q = 1'b1;
			end else if (c == DONT) begin
				if (echo_on_q) begin
					echo_on_q = 1'b0;
					if (echo_ask_q) begin
						r = reply_res(WONT, OPT_ECHO);
						negotiate = 1'b1;
					end
				end
				echo_ask_q = 1'b0;
			end else if (c == WILL) begin
				r = reply_res(DONT, OPT_ECHO);
				negotiate = 1'b1;
			end
		end else if (c == WILL) begin
			r = reply_res(DONT, o);
			negotiate = 1'b1;
		end else if (c == DO) begin
			r = reply_res(WONT, o);
			negotiate = 1'b1;
		end
	endfunction

	function automatic logic filter_byte(input logic [7:0] b, input logic li,
			output filter_res_t r);
		filter_byte = 1'b0;
		r = '0;
		case (phase_q)
			PH_IAC: begin
				if (b == DO || b == DONT || b == WILL || b == WONT) begin
					held_cmd_q = b;
					phase_q = PH_OPT;
				end else begin
					phase_q = PH_DATA;
					r = data_res(b);
					filter_byte = 1'b1;
				end
			end
			PH_OPT: begin
				phase_q = PH_DATA;
				filter_byte = negotiate(held_cmd_q, b, li, r);
			end
			default: begin
				if (b == IAC) begin
					phase_q = PH_IAC;
				end else begin
					phase_q = PH_DATA;
					r = data_res(b);
					filter_byte = 1'b1;
				end
			end
		endcase
	endfunction

	stim_row_t directed_rows [27] = '{
		'{8'h00, 1'b0, 1'b1, 1'b1, data_res(8'h00)},
		'{DONT,  1'b1, 1'b1, 1'b1, data_res(DONT)},
		'{IAC,   1'b0, 1'b1, 1'b0, '0},
		'{IAC,   1'b0, 1'b1, 1'b1, data_res(IAC)},
		'{IAC,   1'b0, 1'b1, 1'b0, '0},
		'{8'h05, 1'b0, 1'b1, 1'b1, data_res(8'h05)},
		'{IAC,   1'b1, 1'b0, 1'b0, '0},
		'{DO,    1'b1, 1'b0, 1'b0, '0},
		'{OPT_ECHO, 1'b1, 1'b1, 1'b1, reply_res(WILL, OPT_ECHO)},
		'{IAC,   1'b1, 1'b0, 1'b0, '0},
		'{DO,    1'b1, 1'b0, 1'b0, '0},
		'{OPT_ECHO, 1'b1, 1'b0, 1'b0, '0},
		'{IAC,   1'b0, 1'b0, 1'b0, '0},
		'{DONT,  1'b0, 1'b0, 1'b0, '0},
		'{OPT_ECHO, 1'b0, 1'b0, 1'b0, '0},
		'{IAC,   1'b0, 1'b0, 1'b0, '0},
		'{WILL,  1'b0, 1'b0, 1'b0, '0},
		'{OPT_ECHO, 1'b0, 1'b1, 1'b1, reply_res(DONT, OPT_ECHO)},
		'{IAC,   1'b1, 1'b0, 1'b0, '0},
		'{WONT,  1'b1, 1'b0, 1'b0, '0},
		'{OPT_ECHO, 1'b1, 1'b0, 1'b0, '0},
		'{IAC,   1'b0, 1'b0, 1'b0, '0},
		'{DO,    1'b0, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b1, 1'b1, reply_res(WONT, 8'hFF)},
		'{IAC,   1'b1, 1'b0, 1'b0, '0},
		'{WILL,  1'b1, 1'b0, 1'b0, '0},
		'{8'h00, 1'b1, 1'b0, 1'b0, '0}
	};

	task automatic send_byte(input logic [7:0] b, input logic li, input logic fixed,
			input logic has, input filter_res_t r);
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			rx_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		rx_valid  <= 1'b1;
		rx_byte   <= b;
		logged_in <= li;
		row_fixed <= fixed;
		row_has   <= has;
		row_res   <= r;
		do @(posedge clk); while (rx_stall);
	endtask

	task automatic send_random(input logic [7:0] b);
		send_byte(b, li_state, 1'b0, 1'b0, '0);
	endtask

	task automatic run_random(input int count);
		int         sent;
		int         pick;
		logic [7:0] c;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 9) == 0)
				li_state = ~li_state;
			if (pick < 35) begin
				send_random(8'($urandom_range(0, 254)));
				sent += 1;
			end else if (pick < 45) begin
				send_random(IAC);
				send_random(IAC);
				sent += 2;
			end else if (pick < 52) begin
				send_random(IAC);
				send_random(8'($urandom_range(0, 250)));
				sent += 2;
			end else if (pick < 92) begin
				case ($urandom_range(0, 3))
					0: c = DO;
					1: c = DONT;
					2: c = WILL;
					default: c = WONT;
				endcase
				send_random(IAC);
				send_random(c);
				if ($urandom_range(0, 1))
					send_random(OPT_ECHO);
				else
					send_random(8'($urandom_range(0, 255)));
				sent += 3;
			end else begin
				send_random(8'($urandom_range(0, 255)));
				sent += 1;
			end
		end
	endtask

	initial begin
		int waited;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 21;
		rx_idle_pct = 76;
		foreach (directed_rows[i])
			send_byte(directed_rows[i].rx, directed_rows[i].li, directed_rows[i].fixed,
				directed_rows[i].has, directed_rows[i].res);
		run_random(NUM_RANDOM / 3);

		tx_idle_pct = 76;
		rx_idle_pct = 21;
		run_random(NUM_RANDOM / 3);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_request = 1'b1;
		run_random(NUM_RANDOM - 2 * (NUM_RANDOM / 3));
		rx_valid <= 1'b0;

		waited = 0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t: %0d results never arrived, next expected %h", $time,
				pending_results.size(), pending_results[0]);
			mismatches++;
		end
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// receiver side: random stalls, one long hold-off once requested
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request && !hold_done) begin
				for (int i = 0; i < HOLD_CYCLES; i++) begin
					res_stall <= 1'b1;
					@(posedge clk);
				end
				hold_done = 1'b1;
			end
			res_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		filter_res_t p;
		filter_res_t e;
		logic        n;
		if (arst_n) begin
			if (rx_valid && !rx_stall) begin
				n = filter_byte(rx_byte, logged_in, p);
				if (row_fixed) begin
					n = row_has;
					p = row_res;
				end
				if (n)
					pending_results.push_back(p);
			end
			if (res_valid && !res_stall) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, %s %b %h %h %h",
						$time, "got kind/data/cmd/opt", out_kind, data_byte,
						reply_cmd, reply_opt);
					mismatches++;
				end else begin
					e = pending_results.pop_front();
					if (out_kind !== e.kind) begin
						$display("%0t: out_kind expected %b got %b", $time, e.kind, out_kind);
						mismatches++;
					end
					if (data_byte !== e.data) begin
						$display("%0t: data_byte expected %h got %h", $time, e.data, data_byte);
						mismatches++;
					end
					if (reply_cmd !== e.cmd) begin
						$display("%0t: reply_cmd expected %h got %h", $time, e.cmd, reply_cmd);
						mismatches++;
					end
					if (reply_opt !== e.opt) begin
						$display("%0t: reply_opt expected %h got %h", $time, e.opt, reply_opt);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		#3ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
